@@ rtl/klsa_pkg.sv @@
// Shared types, codes and defaults for the keyed light slot allocator.
`default_nettype none

package klsa_pkg;

  // Default number of light slots
  localparam int LIGHT_SLOTS_DEF = 32;

  // Width of the reported slot index
  localparam int SLOT_OUT_W = 5;

  // Operation codes
  localparam logic OP_NEW   = 1'b0;
  localparam logic OP_DECAY = 1'b1;

  // Result outcome codes
  typedef enum logic [1:0] {
    OUTC_KEY     = 2'd0,
    OUTC_EXPIRED = 2'd1,
    OUTC_FORCED  = 2'd2,
    OUTC_DECAY   = 2'd3
  } outcome_t;

  // Slot fields that the scan reads back
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] expiry;
    logic [15:0] radius;
    logic [15:0] decay;
  } slot_ent_t;

  // Slot fields that are only stored
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [1:0]         colour;
  } slot_pay_t;

  localparam int ENT_W = $bits(slot_ent_t);
  localparam int PAY_W = $bits(slot_pay_t);

endpackage

`default_nettype wire

@@ rtl/klsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module klsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/keyed_light_slot_allocator.sv @@
// Top level of the keyed light slot allocator: sequencer, scan pipeline and slot RAMs.
// The block takes one item at a time; the slot RAM read port visits one slot per cycle,
//   and a shared expiry comparator and 16x16 multiplier serve every slot.
// in_ready is high only while the sequencer is idle; a finished result may sit in the
//   output register while the next item is taken.
// Reset (rst_n low, synchronous) clears the sequencer, output valid and the per-slot
//   valid bits, so every slot reads as all-zero at once; no clearing pass is needed.
`default_nettype none

module keyed_light_slot_allocator #(
  parameter int LIGHT_SLOTS = klsa_pkg::LIGHT_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic        [15:0] in_light_key,
  input  wire logic        [31:0] in_now,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [15:0] in_pos_z,
  input  wire logic        [15:0] in_start_radius,
  input  wire logic        [15:0] in_lifetime,
  input  wire logic        [1:0]  in_colour,
  input  wire logic        [15:0] in_decay_rate,
  input  wire logic        [15:0] in_frame_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [klsa_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic [1:0]              out_outcome
);

  localparam int IDX_W = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIGHT_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_RESP
  } state_t;

  state_t state_r;

  // Captured item
  logic                 op_r;
  logic [15:0]          key_r;
  logic [31:0]          now_r;
  logic [15:0]          frame_r;
  logic [15:0]          rad_in_r;
  logic [15:0]          life_r;
  logic [15:0]          decay_in_r;
  klsa_pkg::slot_pay_t  pay_r;

  // Scan pipeline: read issue, read data stage, multiply stage
  logic [IDX_W-1:0]     rd_cnt_r;
  logic                 s1_vld_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic                 s2_run_r;
  logic                 s2_live_r;
  logic [IDX_W-1:0]     s2_idx_r;
  logic [31:0]          s2_prod_r;
  klsa_pkg::slot_ent_t  s2_ent_r;

  // Search results of the allocation scan
  logic                 key_hit_r;
  logic                 exp_hit_r;
  logic [IDX_W-1:0]     key_idx_r;
  logic [IDX_W-1:0]     exp_idx_r;

  // One bit per slot: set once the slot has been written since reset
  logic [LIGHT_SLOTS-1:0] valid_r;

  // Output register
  logic                 out_valid_r;
  logic [klsa_pkg::SLOT_OUT_W-1:0] out_slot_r;
  klsa_pkg::outcome_t   out_outcome_r;

  // RAM ports
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [klsa_pkg::ENT_W-1:0] rd_data;
  logic                 wr_en;
  logic                 pay_wr_en;
  logic [IDX_W-1:0]     wr_addr;
  klsa_pkg::slot_ent_t  wr_ent;

  // Datapath
  klsa_pkg::slot_ent_t  ent;
  klsa_pkg::slot_ent_t  new_ent;
  logic                 exp_lt;
  logic                 key_eq;
  logic                 live;
  logic [25:0]          loss;
  logic [15:0]          dec_rad;
  logic [IDX_W-1:0]     pick;
  klsa_pkg::outcome_t   pick_outc;
  logic                 accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign out_valid   = out_valid_r;
  assign out_slot    = out_slot_r;
  assign out_outcome = out_outcome_r;

  // Read one slot per cycle while scanning
  assign rd_en   = (state_r == ST_SCAN);
  assign rd_addr = rd_cnt_r;

  // A slot never written since reset reads as all zero
  assign ent = valid_r[s1_idx_r] ? klsa_pkg::slot_ent_t'(rd_data) : '0;

  // Shared expiry comparator: expired test for allocation, live test for decay
  assign exp_lt = (ent.expiry < now_r);
  assign key_eq = (key_r != '0) && (ent.key == key_r);
  assign live   = !exp_lt && (ent.radius != '0);

  // Loss in 1/16 radius units: frame (1/1024 s) * rate (units/s) * 16
  assign loss    = s2_prod_r[31:6];
  assign dec_rad = (loss >= 26'(s2_ent_r.radius)) ? '0 : (s2_ent_r.radius - loss[15:0]);

  // Key match wins, then the first expired slot, then slot 0
  always_comb begin
    priority if (key_hit_r) begin
      pick      = key_idx_r;
      pick_outc = klsa_pkg::OUTC_KEY;
    end else if (exp_hit_r) begin
      pick      = exp_idx_r;
      pick_outc = klsa_pkg::OUTC_EXPIRED;
    end else begin
      pick      = '0;
      pick_outc = klsa_pkg::OUTC_FORCED;
    end
  end

  always_comb begin
    new_ent.key    = key_r;
    new_ent.expiry = now_r + 32'(life_r);
    new_ent.radius = rad_in_r;
    new_ent.decay  = decay_in_r;
  end

  // Write port: allocation write at the end of a new-light item, otherwise
  // decay write-back from the multiply stage. The two never overlap.
  assign pay_wr_en = (state_r == ST_FINISH) && (op_r == klsa_pkg::OP_NEW);
  assign wr_en     = pay_wr_en || (s2_run_r && s2_live_r);

  always_comb begin
    if (pay_wr_en) begin
      wr_addr = pick;
      wr_ent  = new_ent;
    end else begin
      wr_addr        = s2_idx_r;
      wr_ent         = s2_ent_r;
      wr_ent.radius  = dec_rad;
    end
  end

  klsa_ram #(
    .WIDTH (klsa_pkg::ENT_W),
    .DEPTH (LIGHT_SLOTS),
    .AW    (IDX_W)
  ) u_ent_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (klsa_pkg::ENT_W'(wr_ent)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Origin and colour are stored per slot and never read by the block itself
  klsa_ram #(
    .WIDTH (klsa_pkg::PAY_W),
    .DEPTH (LIGHT_SLOTS),
    .AW    (IDX_W)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (pay_wr_en),
    .wr_addr (pick),
    .wr_data (klsa_pkg::PAY_W'(pay_r)),
    .rd_en   (1'b0),
    .rd_addr ({IDX_W{1'b0}}),
    .rd_data ()
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop a transferred result; the response state reloads it itself
      if (out_valid_r && out_ready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_cnt_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // wait for the last slot to leave both pipeline stages
          if (!s1_vld_r && !s2_run_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (op_r == klsa_pkg::OP_NEW) begin
              out_slot_r    <= klsa_pkg::SLOT_OUT_W'(pick);
              out_outcome_r <= pick_outc;
            end else begin
              out_slot_r    <= '0;
              out_outcome_r <= klsa_pkg::OUTC_DECAY;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Scan control and slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      s1_vld_r  <= 1'b0;
      s2_run_r  <= 1'b0;
      s2_live_r <= 1'b0;
      key_hit_r <= 1'b0;
      exp_hit_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      s1_vld_r  <= rd_en;
      s2_run_r  <= s1_vld_r;
      s2_live_r <= s1_vld_r && (op_r == klsa_pkg::OP_DECAY) && live;
      if (accept) begin
        rd_cnt_r  <= '0;
        key_hit_r <= 1'b0;
        exp_hit_r <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
        // keep the lowest hit of each kind
        if (s1_vld_r && (op_r == klsa_pkg::OP_NEW)) begin
          if (key_eq && !key_hit_r) begin
            key_hit_r <= 1'b1;
          end
          if (exp_lt && !exp_hit_r) begin
            exp_hit_r <= 1'b1;
          end
        end
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Item capture and pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_operation;
      key_r        <= in_light_key;
      now_r        <= in_now;
      frame_r      <= in_frame_time;
      rad_in_r     <= in_start_radius;
      life_r       <= in_lifetime;
      decay_in_r   <= in_decay_rate;
      pay_r.pos_x  <= in_pos_x;
      pay_r.pos_y  <= in_pos_y;
      pay_r.pos_z  <= in_pos_z;
      pay_r.colour <= in_colour;
    end
    s1_idx_r  <= rd_addr;
    s2_idx_r  <= s1_idx_r;
    s2_ent_r  <= ent;
    s2_prod_r <= 32'(frame_r) * 32'(ent.decay);
    if (s1_vld_r && key_eq && !key_hit_r) begin
      key_idx_r <= s1_idx_r;
    end
    if (s1_vld_r && exp_lt && !exp_hit_r) begin
      exp_idx_r <= s1_idx_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/klsa_chk.sv @@
// Port-level checker for the keyed light slot allocator and its bind.
`default_nettype none

module klsa_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [klsa_pkg::SLOT_OUT_W-1:0] out_slot,
  input wire logic [1:0] out_outcome
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_outcome))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One item at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("took a second item while busy");

  // Decay and forced results always report slot 0
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == klsa_pkg::OUTC_DECAY ||
                  out_outcome == klsa_pkg::OUTC_FORCED) |-> out_slot == '0)
    else $error("nonzero slot on decay or forced result");

endmodule

bind keyed_light_slot_allocator klsa_chk u_klsa_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_slot    (out_slot),
  .out_outcome (out_outcome)
);

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the keyed light slot allocator.
`timescale 1ns / 100ps

module tb;

  localparam int LIGHT_SLOTS = klsa_pkg::LIGHT_SLOTS_DEF;
  localparam int NUM_LIGHTS  = 1400;   // total input transfers to offer
  localparam int IDLE_LIMIT  = 4000;   // cycles without any transfer before giving up
  localparam int LONG_HOLD   = 500;    // receiver hold-off length in cycles
  localparam int DRAIN_WAIT  = 60;     // settle time after the last result
  localparam int MAX_PRINTS  = 40;

  // One input item, as driven on the in_ ports, plus a flag that makes the
  // driver hold this item back until every pending result has come out.
  typedef struct packed {
    logic               op;
    logic        [15:0] key;
    logic        [31:0] now;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic        [15:0] radius;
    logic        [15:0] life;
    logic        [1:0]  colour;
    logic        [15:0] decay;
    logic        [15:0] frame;
    logic               drain;
  } light_req_t;

  typedef struct packed {
    logic [klsa_pkg::SLOT_OUT_W-1:0] slot;
    klsa_pkg::outcome_t              outc;
  } slot_grant_t;

  typedef enum logic [1:0] {RG_FILL, RG_CHURN, RG_NOISE, RG_WRAP} regime_t;
  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = 1'b0;
  logic           [15:0] in_light_key = '0;
  logic           [31:0] in_now = '0;
  logic signed    [15:0] in_pos_x = '0;
  logic signed    [15:0] in_pos_y = '0;
  logic signed    [15:0] in_pos_z = '0;
  logic           [15:0] in_start_radius = '0;
  logic           [15:0] in_lifetime = '0;
  logic           [1:0]  in_colour = '0;
  logic           [15:0] in_decay_rate = '0;
  logic           [15:0] in_frame_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [klsa_pkg::SLOT_OUT_W-1:0] out_slot;
  logic           [1:0]  out_outcome;

  keyed_light_slot_allocator #(
    .LIGHT_SLOTS(LIGHT_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_light_key(in_light_key),
    .in_now(in_now),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .in_start_radius(in_start_radius),
    .in_lifetime(in_lifetime),
    .in_colour(in_colour),
    .in_decay_rate(in_decay_rate),
    .in_frame_time(in_frame_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_slot(out_slot),
    .out_outcome(out_outcome)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table, cleared once at time zero to match reset.
  // ---------------------------------------------------------------------------
  logic        [15:0] tbl_key    [LIGHT_SLOTS];
  logic        [31:0] tbl_expiry [LIGHT_SLOTS];
  logic        [15:0] tbl_radius [LIGHT_SLOTS];
  logic        [15:0] tbl_decay  [LIGHT_SLOTS];
  logic        [1:0]  tbl_colour [LIGHT_SLOTS];
  logic signed [15:0] tbl_px     [LIGHT_SLOTS];
  logic signed [15:0] tbl_py     [LIGHT_SLOTS];
  logic signed [15:0] tbl_pz     [LIGHT_SLOTS];

  light_req_t  light_q[$];     // items waiting to be offered
  slot_grant_t grants_due[$];  // expected results, oldest first
  light_req_t  cur = '0;       // item currently offered on the in_ ports

  bit light_taken = 1'b0;      // set at the edge that moved cur, cleared by the driver
  bit holding     = 1'b0;
  bit mark_drain  = 1'b0;
  int gap_left    = 0;
  int burst_left  = 0;
  int lights_taken = 0;
  int idle_cycles  = 0;
  int mismatches   = 0;
  int drains       = 0;
  int holds_done   = 0;
  int outc_seen [4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Slot allocation and decay, applied to the shadow table in transfer order.
  // Returns the slot/outcome pair the block must report for this item.
  // ---------------------------------------------------------------------------
  function automatic slot_grant_t allocate_light(light_req_t r);
    slot_grant_t g;
    logic [31:0] loss;
    bit          found;
    int          pick;
    int          i;
    g.slot = '0;
    g.outc = klsa_pkg::OUTC_DECAY;
    if (r.op == klsa_pkg::OP_DECAY) begin
      // Shrink every live, nonzero radius; clamp at zero.
      for (i = 0; i < LIGHT_SLOTS; i++) begin
        if (tbl_expiry[i] >= r.now && tbl_radius[i] != 16'd0) begin
          loss = ({16'd0, r.frame} * {16'd0, tbl_decay[i]}) >> 6;
          if (loss >= {16'd0, tbl_radius[i]})
            tbl_radius[i] = 16'd0;
          else
            tbl_radius[i] = tbl_radius[i] - loss[15:0];
        end
      end
      return g;
    end
    found  = 1'b0;
    pick   = 0;
    g.outc = klsa_pkg::OUTC_FORCED;
    // A nonzero key reuses the lowest slot that already holds it.
    if (r.key != 16'd0) begin
      for (i = 0; i < LIGHT_SLOTS; i++) begin
        if (!found && tbl_key[i] == r.key) begin
          pick   = i;
          g.outc = klsa_pkg::OUTC_KEY;
          found  = 1'b1;
        end
      end
    end
    // Otherwise the lowest slot that expired strictly before now.
    for (i = 0; i < LIGHT_SLOTS; i++) begin
      if (!found && tbl_expiry[i] < r.now) begin
        pick   = i;
        g.outc = klsa_pkg::OUTC_EXPIRED;
        found  = 1'b1;
      end
    end
    tbl_key[pick]    = r.key;
    tbl_px[pick]     = r.px;
    tbl_py[pick]     = r.py;
    tbl_pz[pick]     = r.pz;
    tbl_radius[pick] = r.radius;
    tbl_expiry[pick] = r.now + {16'd0, r.life};  // wraps at 32 bits
    tbl_colour[pick] = r.colour;
    tbl_decay[pick]  = r.decay;
    g.slot = pick[klsa_pkg::SLOT_OUT_W-1:0];
    return g;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Queue a new-light item; consume the pending drain mark.
  task automatic push_light(input logic [15:0] key, input logic [31:0] now,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] pz, input logic [15:0] radius,
                            input logic [15:0] life, input logic [1:0] colour,
                            input logic [15:0] decay);
    light_req_t r;
    r.op     = klsa_pkg::OP_NEW;
    r.key    = key;
    r.now    = now;
    r.px     = px;
    r.py     = py;
    r.pz     = pz;
    r.radius = radius;
    r.life   = life;
    r.colour = colour;
    r.decay  = decay;
    r.frame  = 16'($urandom);  // ignored by a new-light item
    r.drain  = mark_drain;
    mark_drain = 1'b0;
    light_q.push_back(r);
  endtask

  // Queue a decay pass; the new-light fields carry noise the block must ignore.
  task automatic push_decay(input logic [31:0] now, input logic [15:0] frame);
    light_req_t r;
    r.op     = klsa_pkg::OP_DECAY;
    r.key    = 16'($urandom);
    r.now    = now;
    r.px     = 16'($urandom);
    r.py     = 16'($urandom);
    r.pz     = 16'($urandom);
    r.radius = 16'($urandom);
    r.life   = 16'($urandom);
    r.colour = 2'($urandom_range(0, 3));
    r.decay  = 16'($urandom);
    r.frame  = frame;
    r.drain  = mark_drain;
    mark_drain = 1'b0;
    light_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset: reset is released on a falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge. Work in bursts with random gaps;
  // hold an item marked for draining until every pending result is out.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (light_taken) begin
        light_taken = 1'b0;
        holding     = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (light_q.size() > 0 &&
                     !(light_q[0].drain && grants_due.size() > 0)) begin
          cur     = light_q.pop_front();
          holding = 1'b1;
          if (cur.drain)
            drains++;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Start a new burst; a third of the time leave no gap at all.
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      in_valid <= holding;
      if (holding) begin
        in_operation    <= cur.op;
        in_light_key    <= cur.key;
        in_now          <= cur.now;
        in_pos_x        <= cur.px;
        in_pos_y        <= cur.py;
        in_pos_z        <= cur.pz;
        in_start_radius <= cur.radius;
        in_lifetime     <= cur.life;
        in_colour       <= cur.colour;
        in_decay_rate   <= cur.decay;
        in_frame_time   <= cur.frame;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on its own pattern of steady, coin-flip and sparse modes.
  // Twice, hold out_ready low for a long stretch so the block backs up.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_STEADY;
  int rx_mode_left = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if ((holds_done == 0 && lights_taken >= 400) ||
                 (holds_done == 1 && lights_taken >= 1000)) begin
      hold_left = LONG_HOLD;
      holds_done++;
      rdy = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 150);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_STEADY: rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        default:   rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Check the result transfer against the
  // oldest expectation first, then advance the shadow table for an input
  // transfer at the same edge. Also run the idle watchdog here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    slot_grant_t g;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result slot=%0d outcome=%0d",
                                  out_slot, out_outcome));
        end else begin
          g = grants_due.pop_front();
          outc_seen[g.outc]++;
          if (out_slot !== g.slot)
            flag_mismatch($sformatf("slot %0d, expected %0d", out_slot, g.slot));
          if (out_outcome !== g.outc)
            flag_mismatch($sformatf("outcome %0d, expected %0d", out_outcome, g.outc));
        end
      end
      if (in_valid && in_ready) begin
        grants_due.push_back(allocate_light(cur));
        lights_taken++;
        light_taken = 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still due",
                 IDLE_LIMIT, grants_due.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] key_pool [48];
    logic [31:0] t_base;
    logic [15:0] key;
    logic [15:0] life;
    regime_t     regime;
    int          chunk;
    int          k;
    bit          mid_drain_done;

    for (k = 0; k < LIGHT_SLOTS; k++) begin
      tbl_key[k]    = '0;
      tbl_expiry[k] = '0;
      tbl_radius[k] = '0;
      tbl_decay[k]  = '0;
      tbl_colour[k] = '0;
      tbl_px[k]     = '0;
      tbl_py[k]     = '0;
      tbl_pz[k]     = '0;
    end
    for (k = 0; k < 48; k++)
      key_pool[k] = 16'($urandom_range(1, 65535));

    // Directed: now 0 expires nothing, so the first lights are forced to slot 0.
    push_light(16'h0000, 32'd0, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 2'd0,
               16'h0000);
    push_light(16'h0001, 32'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3,
               16'hFFFF);
    // Same key again reuses its slot; a new key takes the lowest expired slot.
    push_light(16'h0001, 32'd5, 16'h0001, 16'hFFFE, 16'h8000, 16'h1234, 16'h0010, 2'd1,
               16'h0040);
    push_light(16'hFFFF, 32'd5, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 2'd2,
               16'hFFFF);
    push_light(16'hFFFF, 32'd6, 16'h0000, 16'h7FFF, 16'h8000, 16'h00FF, 16'h0400, 2'd1,
               16'h0001);
    // Key zero never matches even though idle slots hold key zero.
    push_light(16'h0000, 32'd6, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 2'd3,
               16'hAAAA);
    push_light(16'h0000, 32'd7, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 2'd0,
               16'h5555);
    // Decay extremes: full frame at full rate clamps, zero frame leaves radii.
    push_decay(32'd7, 16'hFFFF);
    push_decay(32'd7, 16'h0000);
    push_decay(32'd3, 16'h0100);
    // Expiry that wraps past 32 bits reads as already expired.
    push_light(16'h8000, 32'hFFFF_FFF0, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h0100,
               2'd2, 16'h0010);
    push_light(16'h8000, 32'hFFFF_FFF8, 16'h0010, 16'h0020, 16'h0030, 16'h0800, 16'hFFFF,
               2'd1, 16'h0020);
    push_light(16'h1234, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000,
               2'd3, 16'hFFFF);
    push_decay(32'hFFFF_FFFF, 16'hFFFF);
    push_light(16'h8000, 32'h0000_0100, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0001,
               2'd0, 16'h0000);
    push_light(16'h1234, 32'h0000_0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
               2'd2, 16'h0000);
    // Start the random part from an empty pipe.
    mark_drain = 1'b1;

    // Random: chunks of one regime each. Fill keeps lights alive so the table
    // fills and forces slot 0; churn expires lights quickly with a few keys;
    // wrap runs time across the 32-bit boundary; noise is unconstrained.
    t_base = 32'd1000;
    mid_drain_done = 1'b0;
    while (light_q.size() < NUM_LIGHTS) begin
      regime = regime_t'($urandom_range(0, 3));
      chunk  = $urandom_range(20, 60);
      if (regime == RG_WRAP)
        t_base = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      if ($urandom_range(0, 3) == 0)
        mark_drain = 1'b1;
      if (!mid_drain_done && light_q.size() >= NUM_LIGHTS / 2) begin
        mark_drain     = 1'b1;
        mid_drain_done = 1'b1;
      end
      for (k = 0; k < chunk && light_q.size() < NUM_LIGHTS; k++) begin
        case (regime)
          RG_FILL: begin
            t_base = t_base + $urandom_range(0, 3);
            key    = key_pool[$urandom_range(0, 47)];
            life   = 16'($urandom_range(20000, 65535));
          end
          RG_CHURN: begin
            if ($urandom_range(0, 19) == 0)
              t_base = $urandom;
            else
              t_base = t_base + $urandom_range(0, 200);
            key  = key_pool[$urandom_range(0, 7)];
            life = 16'($urandom_range(0, 600));
          end
          RG_WRAP: begin
            t_base = t_base + $urandom_range(0, 40);
            key    = key_pool[$urandom_range(0, 15)];
            life   = 16'($urandom);
          end
          default: begin
            t_base = $urandom;
            key    = 16'($urandom);
            life   = 16'($urandom);
          end
        endcase
        if (regime != RG_NOISE && $urandom_range(0, 15) == 0)
          key = 16'h0000;
        if ($urandom_range(0, 99) < 15)
          push_decay(t_base,
                     16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1500)));
        else
          push_light(key, t_base, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), life, 2'($urandom_range(0, 3)),
                     16'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 255) : $urandom));
      end
    end

    // Wait for every item to transfer and every result to arrive; the
    // watchdog bounds both waits. Then let the pipe settle.
    while (light_q.size() > 0 || holding)
      @(posedge clk);
    while (grants_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transfers: %0d key reuses, %0d expired slots, %0d forced to slot 0,",
             lights_taken, outc_seen[klsa_pkg::OUTC_KEY], outc_seen[klsa_pkg::OUTC_EXPIRED],
             outc_seen[klsa_pkg::OUTC_FORCED]);
    $display("  %0d decay passes, %0d drain pauses, %0d long receiver hold-offs",
             outc_seen[klsa_pkg::OUTC_DECAY], drains, holds_done);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
